[hw/rtl/mprqm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mprqm_pkg
// shared types, sizes and operation codes of the receive queue manager
// ----------------------------------------------------------------------------
package mprqm_pkg;

	localparam int NUM_VPORTS  = 16;
	localparam int NUM_BUFFERS = 64;

	localparam logic [1:0] OP_ENQ  = 2'd0;
	localparam logic [1:0] OP_RECV = 2'd1;
	localparam logic [1:0] OP_POLL = 2'd2;
	localparam logic [1:0] OP_RSVD = 2'd3;

	localparam int OpW   = 2;
	localparam int PortW = $clog2(NUM_VPORTS);
	localparam int BufW  = $clog2(NUM_BUFFERS);

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture input beat
		logic fetch;     // read link entries of the queue front
		logic link_a;    // first list update pass
		logic link_b;    // second list update pass
		logic srch_init; // start signal search at order list head
		logic srch_rd;   // issue memory read for current search node
		logic srch_step; // evaluate node, advance
		logic finish;    // finalize result, set waiting flag if needed
	} ctl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_search; // operation needs a signal search
		logic srch_done; // search hit, ended or exhausted
	} dp_stat_t;

endpackage
`default_nettype wire

[hw/rtl/mprqm_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mprqm_in_if / mprqm_out_if
// valid/ready channels for request and result beats
// ----------------------------------------------------------------------------
interface mprqm_in_if;
	logic                          valid;
	logic                          ready;
	logic [mprqm_pkg::OpW-1:0]     operation;
	logic [mprqm_pkg::PortW-1:0]   vport;
	logic [mprqm_pkg::BufW-1:0]    buffer_id;
	modport source (output valid, operation, vport, buffer_id, input ready);
	modport sink   (input valid, operation, vport, buffer_id, output ready);
endinterface

interface mprqm_out_if;
	logic                          valid;
	logic                          ready;
	logic [mprqm_pkg::BufW-1:0]    out_buffer;
	logic                          queue_was_empty;
	logic [mprqm_pkg::PortW-1:0]   signal_vport;
	logic                          signal_found;
	modport source (output valid, out_buffer, queue_was_empty, signal_vport, signal_found,
		input ready);
	modport sink   (input valid, out_buffer, queue_was_empty, signal_vport, signal_found,
		output ready);
endinterface
`default_nettype wire

[hw/rtl/mprqm_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mprqm_ctrl
// sequencer: accept, apply list updates, walk order list, deliver beat
// ----------------------------------------------------------------------------
module mprqm_ctrl import mprqm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire dp_stat_t stat,
	output ctl_cmd_t      cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_FETCH  = 3'd1;
	localparam logic [2:0] S_LINK_A = 3'd2;
	localparam logic [2:0] S_LINK_B = 3'd3;
	localparam logic [2:0] S_RD     = 3'd4;
	localparam logic [2:0] S_STEP   = 3'd5;
	localparam logic [2:0] S_FIN    = 3'd6;
	localparam logic [2:0] S_OUT    = 3'd7;

	logic [2:0] state_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.load      = in_valid && (state_q == S_IDLE);
		cmd.fetch     = (state_q == S_FETCH);
		cmd.link_a    = (state_q == S_LINK_A);
		cmd.link_b    = (state_q == S_LINK_B);
		cmd.srch_init = (state_q == S_LINK_B);
		cmd.srch_rd   = (state_q == S_RD);
		cmd.srch_step = (state_q == S_STEP);
		cmd.finish    = (state_q == S_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_FETCH;
				S_FETCH:  state_q <= S_LINK_A;
				S_LINK_A: state_q <= S_LINK_B;
				S_LINK_B: state_q <= stat.is_search ? S_RD : S_FIN;
				S_RD: begin
					if (stat.srch_done) state_q <= S_FIN;
					else state_q <= S_STEP;
				end
				S_STEP:   state_q <= stat.srch_done ? S_FIN : S_RD;
				S_FIN:    state_q <= S_OUT;
				S_OUT:    if (out_ready) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while result pending");
	a_fetch_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |-> $past(cmd.load)) else $error("fetch without load");
`endif

endmodule
`default_nettype wire

[hw/rtl/mprqm_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mprqm_dp
// queue and order list storage, list update and search datapath
// ----------------------------------------------------------------------------
module mprqm_dp import mprqm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ctl_cmd_t         cmd,
	output dp_stat_t              stat,
	input  wire logic [OpW-1:0]   operation,
	input  wire logic [PortW-1:0] vport,
	input  wire logic [BufW-1:0]  buffer_id,
	output logic [BufW-1:0]       out_buffer,
	output logic                  queue_was_empty,
	output logic [PortW-1:0]      signal_vport,
	output logic                  signal_found
);

	localparam int NW = BufW + 1;
	localparam int SW = $clog2(NUM_VPORTS + 1);
	localparam logic [NW-1:0] NIL = NW'(NUM_BUFFERS);

	// port tables in flops, buffer link tables in memories
	logic [NW-1:0] qfront_q [NUM_VPORTS];
	logic [NW-1:0] qback_q  [NUM_VPORTS];
	logic [NUM_VPORTS-1:0] wait_q;
	logic [NUM_BUFFERS-1:0] queued_q;
	logic [NW-1:0] ofirst_q, olast_q;

	logic [NW-1:0]    nxt_mem   [NUM_BUFFERS];
	logic [NW-1:0]    oprev_mem [NUM_BUFFERS];
	logic [NW-1:0]    onext_mem [NUM_BUFFERS];
	logic [PortW-1:0] bport_mem [NUM_BUFFERS];

	logic [NW-1:0]    nxt_rd_q, oprev_rd_q, onext_rd_q;
	logic [PortW-1:0] bport_rd_q;

	logic [OpW-1:0]   op_q;
	logic [PortW-1:0] vp_q;
	logic [BufW-1:0]  bid_q;
	logic             vok_q, bok_q, emp_q;
	logic             enq_q, deq_q;
	logic [BufW-1:0]  pop_q;
	logic [NW-1:0]    cur_q;
	logic [SW-1:0]    steps_q;
	logic             found_q;
	logic [PortW-1:0] sport_q;

	logic [PortW-1:0] v;
	logic [BufW-1:0]  b;
	logic [NW-1:0]    tail, front, nx, p, n;
	logic             has_tail, has_last, nx_ok, p_ok, n_ok;
	logic             recv_ok, do_enq, do_pop, cur_ok;

	logic             nxt_we, oprev_we, onext_we, bport_we;
	logic [BufW-1:0]  nxt_wa, oprev_wa, onext_wa, onext_ra;
	logic [NW-1:0]    nxt_wd, oprev_wd, onext_wd;

	assign v        = vp_q;
	assign b        = bid_q;
	assign tail     = qback_q[v];
	assign front    = qfront_q[v];
	assign has_tail = (tail < NIL);
	assign has_last = (olast_q < NIL);
	assign nx       = nxt_rd_q;
	assign p        = oprev_rd_q;
	assign n        = onext_rd_q;
	assign nx_ok    = (nx < NIL);
	assign p_ok     = (p < NIL);
	assign n_ok     = (n < NIL);
	assign recv_ok  = vok_q && (op_q == OP_RECV);
	assign do_enq   = vok_q && bok_q && (op_q == OP_ENQ) && !queued_q[b];
	assign do_pop   = recv_ok && (front < NIL);
	assign cur_ok   = (cur_q < NIL) && (steps_q < SW'(NUM_VPORTS));

	assign stat.is_search = recv_ok || (op_q == OP_POLL);
	assign stat.srch_done = cmd.srch_rd ? !cur_ok : wait_q[bport_rd_q];

	assign out_buffer      = pop_q;
	assign queue_was_empty = emp_q;
	assign signal_vport    = sport_q;
	assign signal_found    = found_q;

	// one write per link table per cycle
	always_comb begin
		nxt_we   = 1'b0;
		nxt_wa   = b;
		nxt_wd   = NIL;
		oprev_we = 1'b0;
		oprev_wa = b;
		oprev_wd = NIL;
		onext_we = 1'b0;
		onext_wa = b;
		onext_wd = NIL;
		bport_we = cmd.link_a && enq_q;
		if (cmd.link_a && enq_q) begin
			nxt_we   = 1'b1;
			oprev_we = 1'b1;
			onext_we = 1'b1;
			oprev_wd = has_tail ? NIL : olast_q;
		end
		if (cmd.link_a && deq_q) begin
			oprev_we = n_ok;
			oprev_wa = n[BufW-1:0];
			oprev_wd = nx_ok ? nx : p;
			onext_we = p_ok;
			onext_wa = p[BufW-1:0];
			onext_wd = nx_ok ? nx : n;
		end
		if (cmd.link_b && enq_q) begin
			nxt_we   = has_tail;
			nxt_wa   = tail[BufW-1:0];
			nxt_wd   = {1'b0, b};
			onext_we = !has_tail && has_last;
			onext_wa = olast_q[BufW-1:0];
			onext_wd = {1'b0, b};
		end
		if (cmd.link_b && deq_q) begin
			oprev_we = nx_ok;
			oprev_wa = nx[BufW-1:0];
			oprev_wd = p;
			onext_we = nx_ok;
			onext_wa = nx[BufW-1:0];
			onext_wd = n;
		end
	end

	assign onext_ra = cmd.fetch ? front[BufW-1:0] : cur_q[BufW-1:0];

	always_ff @(posedge clk) begin
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		if (cmd.fetch) nxt_rd_q <= nxt_mem[front[BufW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (oprev_we) oprev_mem[oprev_wa] <= oprev_wd;
		if (cmd.fetch) oprev_rd_q <= oprev_mem[front[BufW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (onext_we) onext_mem[onext_wa] <= onext_wd;
		if (cmd.fetch || cmd.srch_rd) onext_rd_q <= onext_mem[onext_ra];
	end

	always_ff @(posedge clk) begin
		if (bport_we) bport_mem[b] <= v;
		if (cmd.srch_rd) bport_rd_q <= bport_mem[cur_q[BufW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VPORTS; i++) begin
				qfront_q[i] <= NIL;
				qback_q[i]  <= NIL;
			end
			wait_q   <= '0;
			queued_q <= '0;
			ofirst_q <= NIL;
			olast_q  <= NIL;
			found_q  <= 1'b0;
			emp_q    <= 1'b0;
			pop_q    <= '0;
			sport_q  <= '0;
		end else begin
			if (cmd.load) begin
				found_q <= 1'b0;
				emp_q   <= 1'b0;
				pop_q   <= '0;
				sport_q <= '0;
			end
			if (cmd.link_a && recv_ok) begin
				if (deq_q) begin
					queued_q[front[BufW-1:0]] <= 1'b0;
					qfront_q[v] <= nx;
					if (!nx_ok) qback_q[v] <= NIL;
					if (!p_ok) ofirst_q <= nx_ok ? nx : n;
					if (!n_ok) olast_q <= nx_ok ? nx : p;
					wait_q[v] <= 1'b0;
					pop_q     <= front[BufW-1:0];
				end else begin
					emp_q <= 1'b1;
				end
			end
			if (cmd.link_b && enq_q) begin
				queued_q[b] <= 1'b1;
				qback_q[v]  <= {1'b0, b};
				if (!has_tail) begin
					qfront_q[v] <= {1'b0, b};
					olast_q     <= {1'b0, b};
					if (!has_last) ofirst_q <= {1'b0, b};
				end
			end
			if (cmd.srch_step && wait_q[bport_rd_q]) begin
				wait_q[bport_rd_q] <= 1'b0;
				found_q <= 1'b1;
				sport_q <= bport_rd_q;
			end
			if (cmd.finish && emp_q) wait_q[v] <= 1'b1;
		end
	end

	// capture registers and search walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			vp_q  <= vport;
			bid_q <= buffer_id;
			vok_q <= (32'(vport) < NUM_VPORTS);
			bok_q <= (32'(buffer_id) < NUM_BUFFERS);
		end
		if (cmd.fetch) begin
			enq_q <= do_enq;
			deq_q <= do_pop;
		end
		if (cmd.srch_init) begin
			cur_q   <= ofirst_q;
			steps_q <= '0;
		end
		if (cmd.srch_step) begin
			cur_q   <= onext_rd_q;
			steps_q <= steps_q + SW'(1);
		end
	end

`ifndef ASSERT_OFF
	a_found_flag_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.srch_step && stat.srch_done |=> !wait_q[$past(bport_rd_q)])
		else $error("found flag not cleared");
	a_empty_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		emp_q |-> pop_q == '0) else $error("empty receive popped buffer");
	a_order_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(ofirst_q < NIL) == (olast_q < NIL)) else $error("order list ends disagree");
`endif

endmodule
`default_nettype wire

[hw/rtl/multi_port_receive_queue_manager.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// multi_port_receive_queue_manager
// per-port linked receive queues with ordered signal search
// ----------------------------------------------------------------------------
// sequence: an enqueue passes fetch, two list update passes and finish to the
//   result beat; receive/poll add a read and a step per order list node visited,
//   ending on a hit, when the walk runs off the list or reaches NUM_VPORTS nodes
// requests: one at a time; the next is accepted in the cycle after the result beat is taken
// reset: arst_n clears queue heads, order list ends and waiting flags at once
module multi_port_receive_queue_manager import mprqm_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mprqm_in_if.sink    req,
	mprqm_out_if.source rsp
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	mprqm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mprqm_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.operation       (req.operation),
		.vport           (req.vport),
		.buffer_id       (req.buffer_id),
		.out_buffer      (rsp.out_buffer),
		.queue_was_empty (rsp.queue_was_empty),
		.signal_vport    (rsp.signal_vport),
		.signal_found    (rsp.signal_found)
	);

endmodule
`default_nettype wire
